/* rtl/core/imad_pkg.sv */
package imad_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned IDX_W      = 7;
    localparam int unsigned STEP_W     = 15;
    localparam int unsigned POS_W      = 24;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;

    // register indexes of the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOUND_LENGTH = 2'd0,
        CFG_LOOP_ENABLE  = 2'd1,
        CFG_MONO_MODE    = 2'd2
    } t_cfg_idx;

    // per-channel decoder state
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pred;
        logic [IDX_W-1:0]           idx;
    } t_chan;

    localparam logic signed [4:0] IDX_ADJ [0:7] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
        15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
        15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
        15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
        15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
        15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
        15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
        15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
        15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    localparam logic signed [SAMPLE_W+1:0] PCM_MAX = 18'sd32767;
    localparam logic signed [SAMPLE_W+1:0] PCM_MIN = -18'sd32768;

endpackage

/* rtl/core/imad_if.sv */
interface imad_cfg_if import imad_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface imad_in_if import imad_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_clip;

    modport source (output valid, data_byte, new_clip, input ready);
    modport sink   (input valid, data_byte, new_clip, output ready);
endinterface

interface imad_out_if import imad_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       stopped;
    logic                       last_of_item;

    modport source (output valid, left_sample, right_sample, stopped, last_of_item,
                    input ready);
    modport sink   (input valid, left_sample, right_sample, stopped, last_of_item,
                    output ready);
endinterface

/* rtl/core/ima_adpcm_decoder_core.sv */
// An item sits in the input register, is decoded once the output register is free, and
// its result shows from the output register in the cycle after that decode.
// Stereo and stopped items yield one result, mono items two (the shared channel-0
// nibble unit decodes the low then the high nibble, each a dependent step).
// Reset (i_rst_n low, synchronous): registers go to length 1, no loop, mono; both
// predictors, step indexes, the byte position and the stopped flag clear.
module ima_adpcm_decoder_core import imad_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    imad_cfg_if.sink  i_cfg,
    imad_in_if.sink   i_in,
    imad_out_if.source o_out
);

    // ---------------------------------------------------------------- config
    logic [POS_W-1:0] r_sound_length;
    logic             r_loop_enable;
    logic             r_mono_mode;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_length <= POS_W'(1);
            r_loop_enable  <= 1'b0;
            r_mono_mode    <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SOUND_LENGTH: r_sound_length <= i_cfg.data[POS_W-1:0];
                CFG_LOOP_ENABLE:  r_loop_enable  <= i_cfg.data[0];
                CFG_MONO_MODE:    r_mono_mode    <= i_cfg.data[0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- state
    t_chan            r_chan [2];
    logic [POS_W-1:0] r_pos;
    logic             r_stopped;

    // input register; r_phase marks the second (high) nibble of a mono byte
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_new;
    logic       r_phase;

    // output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_left;
    logic signed [SAMPLE_W-1:0] r_out_right;
    logic                       r_out_stopped;
    logic                       r_out_last;

    // ---------------------------------------------------------------- decode
    logic             out_free;
    logic             fire;
    logic             done;
    logic [POS_W-1:0] pos_eff;
    logic             stop_eff;
    logic             at_end;
    logic             wrap;
    logic             clr;
    logic             stop_now;
    t_chan            chan_in0;
    t_chan            chan_in1;
    t_chan            chan_out0;
    t_chan            chan_out1;
    logic [3:0]       code0;

    t_chan            n_chan [2];
    logic [POS_W-1:0] n_pos;
    logic             n_stopped;
    logic             n_phase;
    logic signed [SAMPLE_W-1:0] n_out_left;
    logic signed [SAMPLE_W-1:0] n_out_right;
    logic             n_out_stopped;
    logic             n_out_last;

    assign out_free = !r_out_valid || o_out.ready;
    assign fire     = r_in_valid && out_free;

    // new_clip clears first, then the clip-end check runs on what is left
    assign pos_eff  = r_in_new ? '0 : r_pos;
    assign stop_eff = r_in_new ? 1'b0 : r_stopped;
    assign at_end   = !stop_eff && (pos_eff >= r_sound_length);
    assign wrap     = at_end && r_loop_enable;
    assign clr      = r_in_new || wrap;
    assign stop_now = stop_eff || (at_end && !r_loop_enable);

    // an item leaves the input register after its last result
    assign done       = r_phase || stop_now || !r_mono_mode;
    assign i_in.ready = !r_in_valid || (fire && done);

    // the clip-end clear only applies on the first nibble of a byte
    assign chan_in0 = (!r_phase && clr) ? t_chan'('0) : r_chan[0];
    assign chan_in1 = clr ? t_chan'('0) : r_chan[1];
    assign code0    = r_phase ? r_in_byte[7:4] : r_in_byte[3:0];

    imad_nib u_nib0 (
        .i_chan (chan_in0),
        .i_code (code0),
        .o_chan (chan_out0)
    );

    imad_nib u_nib1 (
        .i_chan (chan_in1),
        .i_code (r_in_byte[7:4]),
        .o_chan (chan_out1)
    );

    always_comb begin
        n_chan[0]     = r_chan[0];
        n_chan[1]     = r_chan[1];
        n_pos         = r_pos;
        n_stopped     = r_stopped;
        n_phase       = r_phase;
        n_out_left    = chan_out0.pred;
        n_out_right   = chan_out0.pred;
        n_out_stopped = 1'b0;
        n_out_last    = 1'b1;
        if (r_phase) begin
            // mono high nibble
            n_chan[0] = chan_out0;
            n_phase   = 1'b0;
        end else if (stop_now) begin
            // clip over: one zero result, only a new_clip clear sticks
            n_chan[0]     = chan_in0;
            n_chan[1]     = chan_in1;
            n_pos         = pos_eff;
            n_stopped     = 1'b1;
            n_out_left    = '0;
            n_out_right   = '0;
            n_out_stopped = 1'b1;
        end else begin
            n_pos     = (wrap ? '0 : pos_eff) + POS_W'(1);
            n_stopped = 1'b0;
            n_chan[0] = chan_out0;
            if (r_mono_mode) begin
                n_chan[1]  = chan_in1;
                n_phase    = 1'b1;
                n_out_last = 1'b0;
            end else begin
                n_chan[1]   = chan_out1;
                n_out_right = chan_out1.pred;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan[0]   <= '0;
            r_chan[1]   <= '0;
            r_pos       <= '0;
            r_stopped   <= 1'b0;
            r_phase     <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire && done) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_chan[0]   <= n_chan[0];
                r_chan[1]   <= n_chan[1];
                r_pos       <= n_pos;
                r_stopped   <= n_stopped;
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_new  <= i_in.new_clip;
        end
        if (fire) begin
            r_out_left    <= n_out_left;
            r_out_right   <= n_out_right;
            r_out_stopped <= n_out_stopped;
            r_out_last    <= n_out_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.left_sample  = r_out_left;
    assign o_out.right_sample = r_out_right;
    assign o_out.stopped      = r_out_stopped;
    assign o_out.last_of_item = r_out_last;

    // ---------------------------------------------------------------- checks
    a_phase_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_in_valid)
        else $error("high nibble pending without a held item");

    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stopped) |->
            (r_out_left == '0 && r_out_right == '0 && r_out_last))
        else $error("stopped result carries samples");

    a_first_nibble_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !done) |=> (r_phase && r_out_valid && !r_out_last))
        else $error("mono first nibble not followed by high nibble phase");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chan[0].idx <= IDX_MAX) && (r_chan[1].idx <= IDX_MAX))
        else $error("step index out of table");

endmodule

/* rtl/core/imad_nib.sv */
// One IMA nibble decode: step lookup, difference, saturating add, index update.
module imad_nib import imad_pkg::*; (
    input  t_chan      i_chan,
    input  logic [3:0] i_code,
    output t_chan      o_chan
);

    logic [IDX_W-1:0]           si;
    logic [STEP_W-1:0]          step;
    logic signed [IDX_W+1:0]    idx_sum;
    logic [STEP_W+1:0]          diff;
    logic signed [SAMPLE_W+1:0] amp;

    always_comb begin
        si   = (i_chan.idx > IDX_MAX) ? IDX_MAX : i_chan.idx;
        step = STEP_TABLE[si];

        idx_sum = signed'({2'b00, si}) + (IDX_W+2)'(IDX_ADJ[i_code[2:0]]);
        if (idx_sum < 0) begin
            o_chan.idx = '0;
        end else if (idx_sum > signed'({2'b00, IDX_MAX})) begin
            o_chan.idx = IDX_MAX;
        end else begin
            o_chan.idx = idx_sum[IDX_W-1:0];
        end

        diff = {5'b0, step[STEP_W-1:3]}
             + (i_code[0] ? {4'b0, step[STEP_W-1:2]} : '0)
             + (i_code[1] ? {3'b0, step[STEP_W-1:1]} : '0)
             + (i_code[2] ? {2'b0, step} : '0);

        if (i_code[3]) begin
            amp = {{2{i_chan.pred[SAMPLE_W-1]}}, i_chan.pred} - signed'({1'b0, diff});
        end else begin
            amp = {{2{i_chan.pred[SAMPLE_W-1]}}, i_chan.pred} + signed'({1'b0, diff});
        end

        if (amp > PCM_MAX) begin
            o_chan.pred = PCM_MAX[SAMPLE_W-1:0];
        end else if (amp < PCM_MIN) begin
            o_chan.pred = PCM_MIN[SAMPLE_W-1:0];
        end else begin
            o_chan.pred = amp[SAMPLE_W-1:0];
        end
    end

endmodule
